/* rtl/rcmv_pkg.sv */
// shared types, sizes and the microcode program of the rod-cutting solver
// no dependencies; used by every module under rtl
package rcmv_pkg;

    localparam int MAX_LEN    = 64;
    localparam int IDX_BITS   = $clog2(MAX_LEN);
    localparam int LEN_BITS   = 7;
    localparam int PRICE_BITS = 16;
    localparam int VAL_BITS   = 22;
    localparam int STEP_BITS  = 3;

    typedef logic [STEP_BITS-1:0] t_step;

    // program addresses
    localparam t_step STEP_NEW_N = 3'd0;
    localparam t_step STEP_LOAD  = 3'd1;
    localparam t_step STEP_PAIR  = 3'd2;
    localparam t_step STEP_STORE = 3'd3;
    localparam t_step STEP_DONE  = 3'd4;

    typedef enum logic [1:0] {
        COND_NEVER     = 2'd0,
        COND_PAIR_LEFT = 2'd1,
        COND_NOT_LAST  = 2'd2,
        COND_OUT_BUSY  = 2'd3
    } t_cond_sel;

    // one control word
    typedef struct packed {
        logic      price_rd;
        logic      cur_load;
        logic      pair;
        logic      store;
        logic      emit;
        logic      fin;
        t_cond_sel cond;
        t_step     target;
    } t_uop;

    // datapath conditions seen by the sequencer
    typedef struct packed {
        logic pair_left;
        logic not_last;
        logic out_busy;
    } t_cond;

    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u = '0;
        unique case (step)
            STEP_NEW_N: begin
                u.price_rd = 1'b1;
            end
            STEP_LOAD: begin
                u.cur_load = 1'b1;
            end
            STEP_PAIR: begin
                u.pair   = 1'b1;
                u.cond   = COND_PAIR_LEFT;
                u.target = STEP_PAIR;
            end
            STEP_STORE: begin
                u.store  = 1'b1;
                u.cond   = COND_NOT_LAST;
                u.target = STEP_NEW_N;
            end
            STEP_DONE: begin
                u.emit   = 1'b1;
                u.fin    = 1'b1;
                u.cond   = COND_OUT_BUSY;
                u.target = STEP_DONE;
            end
            default: begin
                u.fin = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

/* rtl/rod_cutting_max_value.sv */
// rod-cutting best-value solver, top level with the datapath
// depends on rcmv_pkg, rcmv_price_store, rcmv_best_store, rcmv_sequencer
//
// input channel: i_valid / o_stall with i_op, i_length, i_price
//   op 0 loads the price of one piece length (1..64, others ignored)
//   op 1 solves for a rod length; lengths above 64 are taken as 64
// output channel: o_valid / i_stall with o_best_value, one item per solve
// a solve of length L walks lengths 1..L; each length takes a price
// read, a load, one pair of table reads per cycle on the two read ports
// of the best table while pairs are left, and a store; then the result
// is handed to the output register, and the next item can be taken in
// the cycle the result appears.
// a solve of length zero returns 0 without walking any length.
// one item is worked at a time; o_stall is high while a solve runs.
// the result waits in an output register, so loads are taken while it
// waits; a later solve holds in its last step until the register frees.
// reset (synchronous, active low) zeroes every price, drops any pending
// result and leaves the block ready for an item in the next cycle.
module rod_cutting_max_value (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_op,
    input  logic [rcmv_pkg::LEN_BITS-1:0]   i_length,
    input  logic [rcmv_pkg::PRICE_BITS-1:0] i_price,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rcmv_pkg::VAL_BITS-1:0]   o_best_value
);

    localparam logic [rcmv_pkg::LEN_BITS-1:0] MaxLen = rcmv_pkg::LEN_BITS'(rcmv_pkg::MAX_LEN);
    localparam logic [rcmv_pkg::LEN_BITS-1:0] One    = rcmv_pkg::LEN_BITS'(1);

    logic                            busy;
    logic                            accept;
    logic                            load_ok;
    logic [rcmv_pkg::LEN_BITS-1:0]   len_sat;
    rcmv_pkg::t_uop                  uop;
    rcmv_pkg::t_cond                 cond;

    logic [rcmv_pkg::LEN_BITS-1:0]   r_len;
    logic [rcmv_pkg::LEN_BITS-1:0]   r_n;
    logic [rcmv_pkg::LEN_BITS-1:0]   r_lo;
    logic [rcmv_pkg::LEN_BITS-1:0]   r_hi;
    logic [rcmv_pkg::VAL_BITS-1:0]   r_cur;
    logic                            r_pend;
    logic                            r_out_valid;
    logic [rcmv_pkg::VAL_BITS-1:0]   r_out;

    logic [rcmv_pkg::LEN_BITS-1:0]   n_m1;
    logic [rcmv_pkg::LEN_BITS-1:0]   len_m1;
    logic [rcmv_pkg::LEN_BITS-1:0]   lo_m1;
    logic [rcmv_pkg::LEN_BITS-1:0]   hi_m1;
    logic [rcmv_pkg::PRICE_BITS-1:0] price_rd;
    logic [rcmv_pkg::VAL_BITS-1:0]   best_a;
    logic [rcmv_pkg::VAL_BITS-1:0]   best_b;
    logic [rcmv_pkg::VAL_BITS:0]     cand;
    logic                            issue;
    logic                            emit;

    assign accept  = i_valid && !busy;
    assign o_stall = busy;
    assign load_ok = (i_length != '0) && (i_length <= MaxLen);
    assign len_sat = (i_length > MaxLen) ? MaxLen : i_length;
    assign len_m1  = i_length - One;
    assign n_m1    = r_n - One;
    assign lo_m1   = r_lo - One;
    assign hi_m1   = r_hi - One;

    assign cond.pair_left = (r_lo <= r_hi);
    assign cond.not_last  = (r_n != r_len);
    assign cond.out_busy  = r_out_valid && i_stall;

    assign issue = uop.pair && cond.pair_left;
    assign emit  = uop.emit && !cond.out_busy;
    assign cand  = {1'b0, best_a} + {1'b0, best_b};

    rcmv_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept && i_op),
        .i_start_step ((i_length == '0) ? rcmv_pkg::STEP_DONE : rcmv_pkg::STEP_NEW_N),
        .i_cond       (cond),
        .o_uop        (uop),
        .o_busy       (busy)
    );

    rcmv_price_store u_price (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && !i_op && load_ok),
        .i_wr_addr (len_m1[rcmv_pkg::IDX_BITS-1:0]),
        .i_wr_data (i_price),
        .i_rd_en   (uop.price_rd),
        .i_rd_addr (n_m1[rcmv_pkg::IDX_BITS-1:0]),
        .o_rd_data (price_rd)
    );

    rcmv_best_store u_best (
        .i_clk       (i_clk),
        .i_wr_en     (uop.store),
        .i_wr_addr   (n_m1[rcmv_pkg::IDX_BITS-1:0]),
        .i_wr_data   (r_cur),
        .i_rd_en     (issue),
        .i_rd_addr_a (lo_m1[rcmv_pkg::IDX_BITS-1:0]),
        .i_rd_addr_b (hi_m1[rcmv_pkg::IDX_BITS-1:0]),
        .o_rd_data_a (best_a),
        .o_rd_data_b (best_b)
    );

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (accept && i_op) begin
            r_len <= len_sat;
            r_n   <= One;
            r_cur <= '0;
        end
        if (uop.price_rd) begin
            r_lo <= One;
            r_hi <= n_m1;
        end
        if (uop.cur_load) begin
            r_cur <= {{(rcmv_pkg::VAL_BITS - rcmv_pkg::PRICE_BITS){1'b0}}, price_rd};
        end
        if (issue) begin
            r_lo <= r_lo + One;
            r_hi <= r_hi - One;
        end
        // fold in the pair read last cycle
        if (uop.pair && r_pend && (cand > {1'b0, r_cur})) begin
            r_cur <= cand[rcmv_pkg::VAL_BITS-1:0];
        end
        if (uop.store && cond.not_last) begin
            r_n <= r_n + One;
        end
        if (emit) begin
            r_out <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (uop.pair) begin
                r_pend <= cond.pair_left;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_best_value = r_out;

endmodule

/* rtl/rcmv_price_store.sv */
// price memory with one valid bit per entry, so reset reads as zero price
// depends on rcmv_pkg
module rcmv_price_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [rcmv_pkg::IDX_BITS-1:0]     i_wr_addr,
    input  logic [rcmv_pkg::PRICE_BITS-1:0]   i_wr_data,
    input  logic                              i_rd_en,
    input  logic [rcmv_pkg::IDX_BITS-1:0]     i_rd_addr,
    output logic [rcmv_pkg::PRICE_BITS-1:0]   o_rd_data
);

    logic [rcmv_pkg::PRICE_BITS-1:0] r_mem [rcmv_pkg::MAX_LEN];
    logic [rcmv_pkg::MAX_LEN-1:0]    r_valid;
    logic [rcmv_pkg::PRICE_BITS-1:0] r_rd_data;
    logic                            r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* rtl/rcmv_best_store.sv */
// best-value table: one write port, two registered read ports
// depends on rcmv_pkg
module rcmv_best_store (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [rcmv_pkg::IDX_BITS-1:0]   i_wr_addr,
    input  logic [rcmv_pkg::VAL_BITS-1:0]   i_wr_data,
    input  logic                            i_rd_en,
    input  logic [rcmv_pkg::IDX_BITS-1:0]   i_rd_addr_a,
    input  logic [rcmv_pkg::IDX_BITS-1:0]   i_rd_addr_b,
    output logic [rcmv_pkg::VAL_BITS-1:0]   o_rd_data_a,
    output logic [rcmv_pkg::VAL_BITS-1:0]   o_rd_data_b
);

    logic [rcmv_pkg::VAL_BITS-1:0] r_mem [rcmv_pkg::MAX_LEN];
    logic [rcmv_pkg::VAL_BITS-1:0] r_rd_a;
    logic [rcmv_pkg::VAL_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* rtl/rcmv_sequencer.sv */
// step counter over the microcode table with conditional jumps
// depends on rcmv_pkg (program, control word and condition types)
module rcmv_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rcmv_pkg::t_step      i_start_step,
    input  rcmv_pkg::t_cond      i_cond,
    output rcmv_pkg::t_uop       o_uop,
    output logic                 o_busy
);

    logic            r_busy;
    rcmv_pkg::t_step r_step;
    rcmv_pkg::t_uop  uop;
    logic            take;

    always_comb begin
        uop = rcmv_pkg::uop_rom(r_step);
        case (uop.cond)
            rcmv_pkg::COND_PAIR_LEFT: take = i_cond.pair_left;
            rcmv_pkg::COND_NOT_LAST:  take = i_cond.not_last;
            rcmv_pkg::COND_OUT_BUSY:  take = i_cond.out_busy;
            default:                  take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= rcmv_pkg::STEP_NEW_N;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= i_start_step;
        end else if (r_busy) begin
            if (take) begin
                r_step <= uop.target;
            end else if (uop.fin) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_uop  = r_busy ? uop : '0;
    assign o_busy = r_busy;

endmodule
